[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge outside of reset.
`define STC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stc_pkg.sv]
// Types, constants, calendar functions and the control program of the date converter.
package stc_pkg;

    localparam int unsigned IN_W    = 32;
    localparam int unsigned OUT_W   = 40;
    localparam int unsigned PART_W  = 17;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 26;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic [3:0] t_pc;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_IN,
        SRC_REM,
        SRC_DAYS5
    } t_src;

    typedef enum logic [1:0] {
        DS_DAY,
        DS_HOUR,
        DS_MIN,
        DS_WEEK
    } t_dsel;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_DAYS,
        ST_HOUR,
        ST_MINSEC,
        ST_WDAY
    } t_store;

    typedef enum logic [1:0] {
        WK_NONE,
        WK_BLOCK,
        WK_YEAR,
        WK_MONTH
    } t_walk;

    typedef enum logic [1:0] {
        J_NEXT,
        J_IN,
        J_WALK,
        J_OUT
    } t_jmp;

    typedef struct packed {
        t_src   src;
        t_dsel  dsel;
        logic   div_en;
        t_store store;
        t_walk  walk;
        logic   emit;
        t_jmp   jmp;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic  load;
        logic  step;
        t_dsel dsel;
    } t_div_ctl;

    typedef struct packed {
        logic [PART_W-1:0]  divisor;
        logic [2:0]         pre;
        logic [MUL_B_W-1:0] magic;
        logic [5:0]         post;
    } t_div_cfg;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_DDIV   = 4'd1;
    localparam t_pc PC_DSTORE = 4'd2;
    localparam t_pc PC_HDIV   = 4'd3;
    localparam t_pc PC_HSTORE = 4'd4;
    localparam t_pc PC_MDIV   = 4'd5;
    localparam t_pc PC_MSTORE = 4'd6;
    localparam t_pc PC_WDIV   = 4'd7;
    localparam t_pc PC_WSTORE = 4'd8;
    localparam t_pc PC_BLOCK  = 4'd9;
    localparam t_pc PC_YEAR   = 4'd10;
    localparam t_pc PC_MONTH  = 4'd11;
    localparam t_pc PC_EMIT   = 4'd12;

    localparam logic [7:0] CENT_1 = 8'd100;
    localparam logic [7:0] CENT_2 = 8'd200;

    function automatic t_div_cfg div_cfg(input t_dsel sel);
        t_div_cfg c;
        case (sel)
            DS_DAY:  c = '{divisor: 17'd86400, pre: 3'd7, magic: 26'd50903317, post: 6'd35};
            DS_HOUR: c = '{divisor: 17'd3600,  pre: 3'd4, magic: 26'd9321,     post: 6'd21};
            DS_MIN:  c = '{divisor: 17'd60,    pre: 3'd2, magic: 26'd1093,     post: 6'd14};
            DS_WEEK: c = '{divisor: 17'd7,     pre: 3'd0, magic: 26'd74899,    post: 6'd19};
            default: c = '{divisor: 17'd7,     pre: 3'd0, magic: 26'd74899,    post: 6'd19};
        endcase
        return c;
    endfunction

    function automatic logic is_leap(input logic [7:0] year);
        return (year[1:0] == 2'b00) && (year != CENT_1) && (year != CENT_2);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        d = 5'd31;
            default:                   d = 5'd30;
        endcase
        return d;
    endfunction

    function automatic logic [10:0] walk_amount(input t_walk walk, input logic [7:0] year,
                                                input logic [3:0] month);
        logic [10:0] a;
        case (walk)
            WK_BLOCK: a = ((year == CENT_1) || (year == CENT_2)) ? 11'd1460 : 11'd1461;
            WK_YEAR:  a = is_leap(year) ? 11'd366 : 11'd365;
            WK_MONTH: a = 11'(month_days(month, is_leap(year)));
            default:  a = 11'd0;
        endcase
        return a;
    endfunction

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{src: SRC_NONE, dsel: DS_DAY, div_en: 1'b0, store: ST_NONE, walk: WK_NONE,
              emit: 1'b0, jmp: J_NEXT, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                w.src  = SRC_IN;
                w.dsel = DS_DAY;
                w.jmp  = J_IN;
            end
            PC_DDIV, PC_HDIV, PC_MDIV, PC_WDIV: begin
                w.div_en = 1'b1;
            end
            PC_DSTORE: begin
                w.store = ST_DAYS;
                w.src   = SRC_REM;
                w.dsel  = DS_HOUR;
            end
            PC_HSTORE: begin
                w.store = ST_HOUR;
                w.src   = SRC_REM;
                w.dsel  = DS_MIN;
            end
            PC_MSTORE: begin
                w.store = ST_MINSEC;
                w.src   = SRC_DAYS5;
                w.dsel  = DS_WEEK;
            end
            PC_WSTORE: w.store = ST_WDAY;
            PC_BLOCK: begin
                w.walk = WK_BLOCK;
                w.jmp  = J_WALK;
            end
            PC_YEAR: begin
                w.walk = WK_YEAR;
                w.jmp  = J_WALK;
            end
            PC_MONTH: begin
                w.walk = WK_MONTH;
                w.jmp  = J_WALK;
            end
            PC_EMIT: begin
                w.emit   = 1'b1;
                w.jmp    = J_OUT;
                w.target = PC_IDLE;
            end
            default: w.jmp = J_OUT;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/stc_div.sv]
// Shared divider by a small set of constants, using reciprocal multiplication.
module stc_div import stc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [IN_W-1:0]   i_src,
    output logic [PART_W-1:0] o_part,
    output logic [DAYS_W-1:0] o_quo
);

    logic [IN_W-1:0]    r_num, n_num;
    t_dsel              r_sel, n_sel;
    logic [DAYS_W-1:0]  r_quo, n_quo;
    t_div_cfg           cfg;
    logic [MUL_A_W-1:0] mul_a;
    logic [PROD_W-1:0]  prod;
    logic [PART_W-1:0]  back;

    assign cfg   = div_cfg(r_sel);
    assign mul_a = MUL_A_W'(r_num >> cfg.pre);
    assign prod  = PROD_W'(mul_a) * PROD_W'(cfg.magic);
    assign back  = PART_W'(r_quo) * cfg.divisor;

    always_comb begin
        n_num = r_num;
        n_sel = r_sel;
        n_quo = r_quo;
        if (i_ctl.load) begin
            n_num = i_src;
            n_sel = i_ctl.dsel;
        end else if (i_ctl.step) begin
            n_quo = DAYS_W'(prod >> cfg.post);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= DS_DAY;
        end else begin
            r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
    end

    assign o_part = PART_W'(r_num) - back;
    assign o_quo  = r_quo;

endmodule

[hw/rtl/seconds_to_calendar_date.sv]
// Top level of the converter from seconds since 2000 to calendar date and time.
// A result follows its input transfer through eight divide steps by
// reciprocal multiplication, one step per four-year block, leftover year and month walked,
// one closing step per walk and the output step, which waits while the output is full.
// The next input transfer is taken in the cycle after the result is loaded, so inputs are
// taken one at a time; reset returns the sequencer to idle and empties the output.
`include "assert_macros.svh"
module seconds_to_calendar_date import stc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // epoch_seconds
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata    // year_offset, month_number, day_of_month,
                                           // weekday_number, hour_value, minute_value,
                                           // second_value, zero padding
);

    t_pc               r_pc, n_pc;
    t_uword            uw;
    t_div_ctl          div_ctl;
    logic [IN_W-1:0]   div_src;
    logic [PART_W-1:0] div_part;
    logic [DAYS_W-1:0] div_quo;
    logic              in_acc;
    logic              out_free;
    logic              take;
    logic [10:0]       amount;

    logic [DAYS_W-1:0] r_days;
    logic [DAYS_W-1:0] r_left, n_left;
    logic [7:0]        r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [5:0]        r_sec;
    logic [2:0]        r_wday;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out;

    assign uw       = ucode(r_pc);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign amount   = walk_amount(uw.walk, r_year, r_month);
    assign take     = (uw.walk != WK_NONE) && (r_left >= DAYS_W'(amount))
                      && !((uw.walk == WK_MONTH) && (r_month >= 4'd12));

    always_comb begin
        case (uw.src)
            SRC_IN:    div_src = i_s_tdata;
            SRC_REM:   div_src = IN_W'(div_part);
            SRC_DAYS5: div_src = IN_W'(r_days) + IN_W'(5);
            default:   div_src = '0;
        endcase
        div_ctl.load = (uw.src != SRC_NONE) && ((uw.jmp != J_IN) || in_acc);
        div_ctl.step = uw.div_en;
        div_ctl.dsel = uw.dsel;
    end

    stc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_src   (div_src),
        .o_part  (div_part),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_pc = r_pc;
        case (uw.jmp)
            J_NEXT:  n_pc = r_pc + 4'd1;
            J_IN:    if (in_acc) n_pc = r_pc + 4'd1;
            J_WALK:  if (!take) n_pc = r_pc + 4'd1;
            J_OUT:   if (out_free) n_pc = uw.target;
            default: n_pc = PC_IDLE;
        endcase
    end

    always_comb begin
        n_left      = r_left;
        n_year      = r_year;
        n_month     = r_month;
        n_out_valid = r_out_valid;
        if (uw.store == ST_DAYS) begin
            n_left  = div_quo[DAYS_W-1:0];
            n_year  = 8'd0;
            n_month = 4'd1;
        end
        if (take) begin
            n_left = r_left - DAYS_W'(amount);
            case (uw.walk)
                WK_BLOCK: n_year  = r_year + 8'd4;
                WK_YEAR:  n_year  = r_year + 8'd1;
                WK_MONTH: n_month = r_month + 4'd1;
                default:  n_year  = r_year;
            endcase
        end
        if (uw.emit && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_out_valid <= 1'b0;
            r_year      <= 8'd0;
            r_month     <= 4'd1;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_year      <= n_year;
            r_month     <= n_month;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        case (uw.store)
            ST_DAYS:   r_days <= div_quo[DAYS_W-1:0];
            ST_HOUR:   r_hour <= div_quo[4:0];
            ST_MINSEC: begin
                r_min <= div_quo[5:0];
                r_sec <= div_part[5:0];
            end
            ST_WDAY:   r_wday <= div_part[2:0] + 3'd1;
            default:   r_days <= r_days;
        endcase
        if (uw.emit && out_free) begin
            r_out <= {3'b000, r_sec, r_min, r_hour, r_wday,
                      5'(r_left) + 5'd1, r_month, r_year};
        end
    end

    assign o_s_tready = (uw.jmp == J_IN);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    `STC_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_s_tready, "input taken while busy")
    `STC_ASSERT(a_date_range, (r_year <= 8'd136) && (r_month >= 4'd1) && (r_month <= 4'd12),
        "year or month out of range")
    `STC_ASSERT(a_out_nonzero, !o_m_tvalid || ((o_m_tdata[16:12] != 5'd0)
        && (o_m_tdata[19:17] != 3'd0)), "day or weekday of zero in a result")

endmodule

[tb/seconds_to_calendar_date_tb.sv]
// Self-checking testbench for the seconds to calendar date converter.
module seconds_to_calendar_date_tb import stc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DIR_N        = 22;

    typedef struct packed {
        logic [2:0] pad;
        logic [5:0] sec_v;
        logic [5:0] min_v;
        logic [4:0] hour_v;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] month_no;
        logic [7:0] year_off;
    } t_date;

    typedef struct packed {
        logic [31:0] secs;
        logic        typed;
        t_date       want;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [OUT_W-1:0] o_m_tdata;

    t_date       pending_dates[$];
    t_row        dir_rows[DIR_N];
    int unsigned cycles;
    int unsigned errors;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned leap_days_seen;
    int unsigned top_year;
    bit          steady;

    seconds_to_calendar_date uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    function automatic bit leap_year(input int unsigned off);
        int unsigned y;
        y = 2000 + off;
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_length(input int unsigned off);
        return leap_year(off) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input bit leap);
        case (mon)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic t_date calendar_of(input logic [31:0] secs);
        t_date       d;
        int unsigned s;
        int unsigned days;
        int unsigned rem;
        int unsigned left;
        int unsigned yr;
        int unsigned mon;
        s    = secs;
        days = s / SECS_PER_DAY;
        rem  = s % SECS_PER_DAY;
        left = days;
        yr   = 0;
        mon  = 1;
        while (left >= year_length(yr)) begin
            left = left - year_length(yr);
            yr++;
        end
        while (mon < 12 && left >= month_length(mon, leap_year(yr))) begin
            left = left - month_length(mon, leap_year(yr));
            mon++;
        end
        d.pad      = '0;
        d.year_off = 8'(yr);
        d.month_no = 4'(mon);
        d.mday     = 5'(left + 1);
        d.wday     = 3'((days + 5) % 7 + 1);
        d.hour_v   = 5'(rem / 3600);
        d.min_v    = 6'((rem % 3600) / 60);
        d.sec_v    = 6'(rem % 60);
        return d;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_seconds(input logic [31:0] secs);
        while (!steady && $urandom_range(99) < 22) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = secs;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_dates.push_back(calendar_of(secs));
        sent_count++;
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("[seconds_to_calendar_date] ERROR");
        $finish;
    end

    // Output side: random back-pressure plus one long hold so the converter fills up.
    initial begin : result_side
        int unsigned hold_left;
        bit          held;
        hold_left  = 0;
        held       = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else if (!held && sent_count == 60) begin
                held       = 1'b1;
                hold_left  = HOLD_CYCLES;
                i_m_tready = 1'b0;
            end else begin
                i_m_tready = steady || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_date got;
        t_date want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_date'(o_m_tdata);
            if (pending_dates.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time,
                         o_m_tdata);
                errors++;
            end else begin
                want = pending_dates.pop_front();
                check_field("year_offset", want.year_off, got.year_off);
                check_field("month_number", want.month_no, got.month_no);
                check_field("day_of_month", want.mday, got.mday);
                check_field("weekday_number", want.wday, got.wday);
                check_field("hour_value", want.hour_v, got.hour_v);
                check_field("minute_value", want.min_v, got.min_v);
                check_field("second_value", want.sec_v, got.sec_v);
                check_field("padding", want.pad, got.pad);
                checked_count++;
                if (got.year_off > top_year) top_year = got.year_off;
                if (want.month_no == 2 && want.mday == 29) leap_days_seen++;
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned k;
        int unsigned pick;
        int unsigned yr;
        int unsigned mon;
        int unsigned days;
        logic [63:0] wide;
        logic [31:0] secs;
        t_row        r;

        errors         = 0;
        sent_count     = 0;
        checked_count  = 0;
        leap_days_seen = 0;
        top_year       = 0;
        steady         = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;

        dir_rows = '{
            '{secs: 32'd0, typed: 1'b1, want: '{pad: 3'd0, sec_v: 6'd0, min_v: 6'd0,
              hour_v: 5'd0, wday: 3'd6, mday: 5'd1, month_no: 4'd1, year_off: 8'd0}},
            '{secs: 32'd86399, typed: 1'b1, want: '{pad: 3'd0, sec_v: 6'd59, min_v: 6'd59,
              hour_v: 5'd23, wday: 3'd6, mday: 5'd1, month_no: 4'd1, year_off: 8'd0}},
            '{secs: 32'hFFFF_FFFF, typed: 1'b1, want: '{pad: 3'd0, sec_v: 6'd15, min_v: 6'd28,
              hour_v: 5'd6, wday: 3'd2, mday: 5'd7, month_no: 4'd2, year_off: 8'd136}},
            '{secs: 32'd4294944000, typed: 1'b1, want: '{pad: 3'd0, sec_v: 6'd0, min_v: 6'd0,
              hour_v: 5'd0, wday: 3'd2, mday: 5'd7, month_no: 4'd2, year_off: 8'd136}},
            '{secs: 32'd86400,      typed: 1'b0, want: '0},
            '{secs: 32'd5097600,    typed: 1'b0, want: '0},
            '{secs: 32'd5183999,    typed: 1'b0, want: '0},
            '{secs: 32'd5184000,    typed: 1'b0, want: '0},
            '{secs: 32'd31622399,   typed: 1'b0, want: '0},
            '{secs: 32'd31622400,   typed: 1'b0, want: '0},
            '{secs: 32'd36719999,   typed: 1'b0, want: '0},
            '{secs: 32'd36720000,   typed: 1'b0, want: '0},
            '{secs: 32'd3034627200, typed: 1'b0, want: '0},
            '{secs: 32'd3155759999, typed: 1'b0, want: '0},
            '{secs: 32'd3155760000, typed: 1'b0, want: '0},
            '{secs: 32'd3160857599, typed: 1'b0, want: '0},
            '{secs: 32'd3160857600, typed: 1'b0, want: '0},
            '{secs: 32'd4291747200, typed: 1'b0, want: '0},
            '{secs: 32'h8000_0000,  typed: 1'b0, want: '0},
            '{secs: 32'h7FFF_FFFF,  typed: 1'b0, want: '0},
            '{secs: 32'hAAAA_AAAA,  typed: 1'b0, want: '0},
            '{secs: 32'h5555_5555,  typed: 1'b0, want: '0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            r = dir_rows[i];
            if (r.typed && calendar_of(r.secs) != r.want) begin
                $display("%0t ns: predictor disagrees on %0d, expected %h, actual %h", $time,
                         r.secs, r.want, calendar_of(r.secs));
                errors++;
            end
            send_seconds(r.secs);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 150) && (i < 230);
            pick   = $urandom_range(99);
            if (pick < 45) begin
                secs = $urandom;
            end else if (pick < 85) begin
                // Land on month starts and ends, at the first, last or a random second of the day.
                yr   = $urandom_range(136);
                mon  = $urandom_range(1, 12);
                days = 0;
                for (k = 0; k < yr; k++) days += year_length(k);
                for (k = 1; k < mon; k++) days += month_length(k, leap_year(yr));
                if ($urandom_range(1)) days += month_length(mon, leap_year(yr)) - 1;
                wide = 64'(days) * SECS_PER_DAY;
                case ($urandom_range(2))
                    0:       wide = wide + SECS_PER_DAY - 1;
                    1:       wide = wide;
                    default: wide = wide + $urandom_range(SECS_PER_DAY - 1);
                endcase
                secs = wide[31:0];
            end else if ($urandom_range(1)) begin
                secs = $urandom_range(SECS_PER_DAY * 400);
            end else begin
                secs = 32'hFFFF_FFFF - $urandom_range(SECS_PER_DAY * 400);
            end
            send_seconds(secs);
        end
        steady     = 1'b0;
        i_s_tvalid = 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("Sent %0d second counts (%0d directed), checked %0d calendar results.",
                 sent_count, DIR_N, checked_count);
        $display("Highest year offset seen %0d, leap days seen %0d.", top_year,
                 leap_days_seen);
        if (errors == 0) begin
            $display("[seconds_to_calendar_date] OK");
        end else begin
            $display("[seconds_to_calendar_date] ERROR");
        end
        $finish;
    end

endmodule
